// File: rtl/core/four_channel_baseline_threshold_trigger_macros.svh
`ifndef FOUR_CHANNEL_BASELINE_THRESHOLD_TRIGGER_MACROS_SVH
`define FOUR_CHANNEL_BASELINE_THRESHOLD_TRIGGER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FCBTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcbtt assertion failed");

// next-cycle implication, disabled during reset
`define FCBTT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcbtt assertion failed");

`endif

// File: rtl/core/fcbtt_pkg.sv
package fcbtt_pkg;

    localparam int unsigned DEF_MAX_SAMPLES = 4096;
    localparam int unsigned DEF_ADC_BITS    = 12;
    localparam int unsigned DEF_CHANNELS    = 4;

    localparam int unsigned LEN_W  = 12;
    localparam int unsigned WEND_W = 13;
    localparam int unsigned THR_W  = 13;
    localparam int unsigned CNT_W  = 32;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [LEN_W-1:0]         RST_BASELINE_LEN = 12'd90;
    localparam logic [WEND_W-1:0]        RST_WINDOW_END   = 13'd300;
    localparam logic signed [THR_W-1:0]  RST_THRESHOLD    = 13'sd0;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

// File: rtl/core/four_channel_baseline_threshold_trigger.sv
// channel | dir | bits             | contents
// s_axis  | in  | tdata, tlast     | one ADC code per channel, last sample of event
// m_axis  | out | tdata            | per-event trigger result
// cfg     | in  | we, index, wdata | baseline_len, window_end, threshold
//
// One sample per cycle; a sample waits in the input register while the per-channel
// multiply and compare run, and its result is then registered.
// A result is registered in the result register when its last sample leaves the input register.
// Reset clears control, event state, counters and loads the config defaults.
// Only a last sample waits for a stalled result register; other samples flow on.
module four_channel_baseline_threshold_trigger #(
    parameter int unsigned MAX_SAMPLES = fcbtt_pkg::DEF_MAX_SAMPLES,
    parameter int unsigned ADC_BITS    = fcbtt_pkg::DEF_ADC_BITS,
    parameter int unsigned CHANNELS    = fcbtt_pkg::DEF_CHANNELS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // adc_a, adc_b, adc_c, adc_d (ADC_BITS each), zero pad to bytes
    input  logic [((CHANNELS*ADC_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                       s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // event_fired, fired_mask, coincidence_count, event_number, short_event, zero pad
    output logic [((CHANNELS+2*fcbtt_pkg::CNT_W+2+7)/8)*8-1:0] m_axis_tdata,
    input  logic                                       cfg_we,
    input  logic [fcbtt_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [fcbtt_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
    import fcbtt_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned POS_W  = (IDX_W > WEND_W) ? IDX_W : WEND_W;
    localparam int unsigned SUM_W  = ADC_BITS + LEN_W;
    localparam int unsigned DIFF_W = ((ADC_BITS + 1 > THR_W) ? ADC_BITS + 1 : THR_W) + 1;
    localparam int unsigned PROD_W = DIFF_W + LEN_W + 1;
    localparam int unsigned OUT_W  = CHANNELS + 2*CNT_W + 2;
    localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef logic [CHANNELS-1:0][ADC_BITS-1:0] codes_t;
    typedef logic [CHANNELS-1:0][SUM_W-1:0]    sums_t;

    // config
    logic [LEN_W-1:0]        baseline_len_reg;
    logic [WEND_W-1:0]       window_end_reg;
    logic signed [THR_W-1:0] threshold_reg;

    // input register
    logic   in_valid_reg;
    codes_t in_codes_reg;
    logic   in_last_reg;

    // event state
    logic [IDX_W-1:0]    idx_reg, idx_next;
    sums_t               sum_reg, sum_next;
    logic [CHANNELS-1:0] fired_reg, fired_next, fired_upd;
    logic [CNT_W-1:0]    coinc_reg, coinc_next;
    logic [CNT_W-1:0]    evt_reg, evt_next;

    // result register
    logic                out_valid_reg;
    logic                out_fired_reg, out_fired_next;
    logic [CHANNELS-1:0] out_mask_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [CNT_W-1:0]    out_evt_reg;
    logic                out_short_reg, out_short_next;

    logic             out_free;
    logic             proc;
    logic             emit;
    logic             active;
    logic [IDX_W-1:0] idx_adv;
    logic [POS_W-1:0] pos;
    logic             in_base;
    logic             in_win;

    logic signed [PROD_W-1:0] len_s;
    logic signed [DIFF_W-1:0] diff  [CHANNELS];
    logic signed [PROD_W-1:0] prod  [CHANNELS];
    logic signed [PROD_W-1:0] sum_s [CHANNELS];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && (!in_last_reg || out_free);
    assign emit          = proc && in_last_reg;
    assign s_axis_tready = !in_valid_reg || proc;

    assign active  = idx_reg < IDX_W'(MAX_SAMPLES);
    assign idx_adv = active ? idx_reg + 1'b1 : idx_reg;
    assign pos     = POS_W'(idx_reg);
    assign in_base = pos < POS_W'(baseline_len_reg);
    assign in_win  = pos < POS_W'(window_end_reg);
    assign len_s   = signed'(PROD_W'(baseline_len_reg));

    // sum > len*(code - thr) is the exact form of mean - code > -thr
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            diff[c]  = signed'(DIFF_W'(in_codes_reg[c])) - DIFF_W'(threshold_reg);
            prod[c]  = len_s * PROD_W'(diff[c]);
            sum_s[c] = signed'(PROD_W'(sum_reg[c]));
            sum_next[c]  = sum_reg[c];
            fired_upd[c] = fired_reg[c];
            if (active)
            begin
                if (in_base)
                begin
                    sum_next[c] = sum_reg[c] + SUM_W'(in_codes_reg[c]);
                end
                else if (in_win && !fired_reg[c] && (sum_s[c] > prod[c]))
                begin
                    fired_upd[c] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        out_fired_next = &fired_upd;
        out_short_next = POS_W'(idx_adv) < POS_W'(window_end_reg);
        coinc_next     = (out_fired_next && (coinc_reg != CNT_MAX)) ? coinc_reg + 1'b1
                                                                     : coinc_reg;
        evt_next       = evt_reg + 1'b1;
        idx_next       = in_last_reg ? '0 : idx_adv;
        fired_next     = in_last_reg ? '0 : fired_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_len_reg <= RST_BASELINE_LEN;
            window_end_reg   <= RST_WINDOW_END;
            threshold_reg    <= RST_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASELINE_LEN: baseline_len_reg <= cfg_wdata[LEN_W-1:0];
                REG_WINDOW_END:   window_end_reg   <= cfg_wdata[WEND_W-1:0];
                REG_THRESHOLD:    threshold_reg    <= signed'(cfg_wdata[THR_W-1:0]);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            fired_reg     <= '0;
            coinc_reg     <= '0;
            evt_reg       <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                idx_reg   <= idx_next;
                fired_reg <= fired_next;
                sum_reg   <= in_last_reg ? '0 : sum_next;
            end
            if (emit)
            begin
                coinc_reg <= coinc_next;
                evt_reg   <= evt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_codes_reg <= codes_t'(s_axis_tdata[CHANNELS*ADC_BITS-1:0]);
            in_last_reg  <= s_axis_tlast;
        end
        if (emit)
        begin
            out_fired_reg <= out_fired_next;
            out_mask_reg  <= fired_upd;
            out_count_reg <= coinc_next;
            out_evt_reg   <= evt_reg;
            out_short_reg <= out_short_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'({out_short_reg, out_evt_reg, out_count_reg,
                                    out_mask_reg, out_fired_reg});

`include "four_channel_baseline_threshold_trigger_macros.svh"

    `FCBTT_ASSERT_NOW(a_fired_mask, out_valid_reg, !out_fired_reg || (&out_mask_reg))
    `FCBTT_ASSERT_NOW(a_flags_clear_at_start, idx_reg == '0, fired_reg == '0)
    `FCBTT_ASSERT_NXT(a_event_restart, emit, (idx_reg == '0) && (sum_reg == '0))
    `FCBTT_ASSERT_NXT(a_count_monotonic, 1'b1, coinc_reg >= $past(coinc_reg))

endmodule

// File: tb/four_channel_baseline_threshold_trigger_test.sv
module four_channel_baseline_threshold_trigger_test;
    import fcbtt_pkg::*;

    localparam int unsigned SAMPLE_LIMIT = 4096;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    typedef struct {
        bit        fired;
        bit [3:0]  mask;
        bit [31:0] coinc;
        bit [31:0] evnum;
        bit        short_ev;
    } event_result_t;

    class trigger_predictor;
        bit [11:0]         base_len;
        bit [12:0]         win_end;
        bit signed [12:0]  thr;
        int unsigned       sample_count;
        longint            base_sum[4];
        bit                fired[4];
        bit [31:0]         coinc_total;
        bit [31:0]         event_count;
        event_result_t     expected_events[$];
        int                mismatches;

        function new();
            base_len     = RST_BASELINE_LEN;
            win_end      = RST_WINDOW_END;
            thr          = RST_THRESHOLD;
            sample_count = 0;
            coinc_total  = 0;
            event_count  = 0;
            mismatches   = 0;
            for (int c = 0; c < 4; c++)
            begin
                base_sum[c] = 0;
                fired[c]    = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BASELINE_LEN: base_len = val[11:0];
                REG_WINDOW_END:   win_end  = val;
                REG_THRESHOLD:    thr      = val;
                default:          ;
            endcase
        endfunction

        function void record_sample(logic [47:0] data, logic last);
            longint        lhs;
            longint        rhs;
            bit [11:0]     code;
            bit            all_fired;
            event_result_t r;
            if (sample_count < SAMPLE_LIMIT)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    code = data[c*12 +: 12];
                    if (sample_count < base_len)
                        base_sum[c] += longint'(code);
                    else if (sample_count < win_end && !fired[c])
                    begin
                        lhs = base_sum[c] - longint'(base_len) * longint'(code);
                        rhs = -(longint'(base_len) * longint'(thr));
                        if (lhs > rhs)
                            fired[c] = 1;
                    end
                end
                sample_count++;
            end
            if (last)
            begin
                all_fired = 1;
                r.mask = 0;
                for (int c = 0; c < 4; c++)
                begin
                    r.mask[c] = fired[c];
                    if (!fired[c])
                        all_fired = 0;
                end
                if (all_fired && coinc_total != CNT_MAX)
                    coinc_total++;
                r.fired    = all_fired;
                r.coinc    = coinc_total;
                r.evnum    = event_count;
                r.short_ev = sample_count < win_end;
                expected_events.push_back(r);
                event_count++;
                sample_count = 0;
                for (int c = 0; c < 4; c++)
                begin
                    base_sum[c] = 0;
                    fired[c]    = 0;
                end
            end
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_event(logic [71:0] d);
            event_result_t e;
            if (expected_events.size() == 0)
            begin
                note_error($sformatf("unexpected result %h", d));
                return;
            end
            e = expected_events.pop_front();
            if (d[0] !== e.fired || d[4:1] !== e.mask || d[36:5] !== e.coinc
                || d[68:37] !== e.evnum || d[69] !== e.short_ev)
                note_error($sformatf({"event %0d: exp fired %0b mask %h count %0d short %0b, ",
                                      "got fired %b mask %h count %0d num %0d short %b"},
                                     e.evnum, e.fired, e.mask, e.coinc, e.short_ev,
                                     d[0], d[4:1], d[36:5], d[68:37], d[69]));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // adc_a, adc_b, adc_c, adc_d
    logic [47:0]           s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // event_fired, fired_mask, coincidence_count, event_number, short_event, pad
    logic [71:0]           m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BASELINE_LEN;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    trigger_predictor trig;
    int  items_sent = 0;
    int  cycles = 0;
    bit  src_calm = 0;
    bit  sink_calm = 0;
    int  cur_len = RST_BASELINE_LEN;
    int  cur_thr = RST_THRESHOLD;

    four_channel_baseline_threshold_trigger uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= sink_calm || ($urandom_range(99) >= 18);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                trig.record_sample(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                trig.check_event(m_axis_tdata);
        end
    end

    task automatic write_config(bit [11:0] len, bit [12:0] wend, logic signed [12:0] th);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BASELINE_LEN;
        cfg_wdata <= {1'b0, len};
        @(posedge clk);
        cfg_index <= REG_WINDOW_END;
        cfg_wdata <= wend;
        @(posedge clk);
        cfg_index <= REG_THRESHOLD;
        cfg_wdata <= th;
        @(posedge clk);
        cfg_we <= 1'b0;
        trig.write_reg(REG_BASELINE_LEN, {1'b0, len});
        trig.write_reg(REG_WINDOW_END, wend);
        trig.write_reg(REG_THRESHOLD, th);
        cur_len = len;
        cur_thr = th;
    endtask

    task automatic send_sample(logic [47:0] data, logic last);
        while (!src_calm && $urandom_range(99) < 18)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // nb samples of one code, then nw of another, same on all channels
    task automatic send_flat(int nb, logic [11:0] bc, int nw, logic [11:0] wc);
        for (int i = 0; i < nb + nw; i++)
            send_sample(i < nb ? {4{bc}} : {4{wc}}, i == nb + nw - 1);
    endtask

    task automatic send_event(int n, bit noisy);
        int          level;
        int          spread;
        int          code;
        logic [47:0] d;
        level  = $urandom_range(0, 4095);
        spread = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (noisy)
                    code = $urandom_range(0, 4095);
                else if (i < cur_len)
                    code = level + int'($urandom_range(0, 2*spread)) - spread;
                else
                    code = level + cur_thr + int'($urandom_range(0, 2*spread + 2)) - spread - 1;
                if (code < 0)
                    code = 0;
                else if (code > 4095)
                    code = 4095;
                d[c*12 +: 12] = code[11:0];
            end
            send_sample(d, i == n - 1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (trig.expected_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int               start;
        int               n;
        bit [11:0]        len;
        bit [12:0]        wend;
        logic signed [12:0] th;
        trig = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults
        send_event(300, 0);
        send_event(40, 0);
        drain();

        write_config(2, 5, 0);
        send_flat(2, 12'h000, 3, 12'hfff);
        send_flat(2, 12'hfff, 4, 12'h000);
        send_flat(1, 12'h800, 0, 12'h000);
        drain();
        write_config(2, 5, 13'sd4095);
        send_flat(2, 12'h000, 1, 12'hfff);
        send_flat(2, 12'hfff, 1, 12'hfff);
        drain();
        write_config(2, 5, -13'sd4095);
        send_flat(2, 12'hfff, 1, 12'h000);
        drain();
        // empty baseline
        write_config(0, 5, 0);
        send_flat(0, 12'h000, 3, 12'h000);
        drain();
        // window closes before baseline ends
        write_config(4, 3, 13'sd100);
        send_flat(4, 12'hfff, 1, 12'h000);
        drain();
        write_config(1, 0, 0);
        send_flat(1, 12'hfff, 1, 12'h000);
        drain();

        start = items_sent;
        while (items_sent - start < 850)
        begin
            src_calm  = (items_sent - start >= 400) && (items_sent - start < 700);
            sink_calm = src_calm;
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(0, 4095);
            n = $urandom_range(99);
            if (n < 10)
                wend = $urandom_range(0, len);
            else if (n < 16)
                wend = $urandom_range(0, 8191);
            else
                wend = len + $urandom_range(1, 12);
            n = $urandom_range(99);
            if (n < 70)
                th = $urandom_range(0, 80) - 40;
            else if (n < 85)
                th = $urandom_range(1) ? 13'sd4095 : -13'sd4095;
            else
                th = $urandom_range(0, 8191);
            write_config(len, wend, th);
            repeat ($urandom_range(2, 6))
            begin
                if (len > 16 || wend > 40)
                    n = $urandom_range(1, 12);
                else if ($urandom_range(99) < 20)
                    n = $urandom_range(1, wend + 4);
                else
                    n = wend + int'($urandom_range(0, 6)) - 3;
                if (n < 1)
                    n = 1;
                send_event(n, $urandom_range(99) < 15);
            end
            drain();
        end
        src_calm  = 0;
        sink_calm = 0;
        drain();

        if (trig.mismatches == 0 && trig.expected_events.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
